### src/msd_pkg.sv
// msd_pkg: shared widths, register codes and pipeline control type for the
// moving average settle detector. No dependencies.
package msd_pkg;

    localparam int NCH         = 3;
    localparam int IN_W        = 12;
    localparam int SUM_W       = 16;
    localparam int DELTA_W     = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    localparam logic [DELTA_W-1:0] DELTA_RESET = 8'd2;

    typedef enum logic [0:0] {
        REG_SETTLE_DELTA = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic retire;   // stage B word moves into the output register
    } t_pipe_ctl;

endpackage

### src/msd_cfg.sv
// msd_cfg: APB register file holding settle_delta.
// Depends on msd_pkg.
module msd_cfg import msd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DELTA_W-1:0]    o_settle_delta
);

    logic [DELTA_W-1:0] r_settle_delta;
    t_reg_idx           reg_idx;
    logic               wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_delta <= DELTA_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SETTLE_DELTA: r_settle_delta <= pwdata[DELTA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SETTLE_DELTA: prdata = APB_DATA_W'(r_settle_delta);
            default:          prdata = '0;
        endcase
    end

    assign o_settle_delta = r_settle_delta;

endmodule

### src/msd_channel.sv
// msd_channel: circular window and running sum of one sensor channel.
// Depends on msd_pkg.
module msd_channel import msd_pkg::*; #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12,
    parameter int PTR_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_pipe_ctl              i_ctl,
    input  logic [PTR_W-1:0]       i_ptr,
    input  logic [IN_W-1:0]        i_reading,
    output logic [SUM_W-1:0]       o_sum,
    output logic [SAMPLE_BITS-1:0] o_cur
);

    logic [SAMPLE_BITS-1:0] r_win [WINDOW];
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic [SAMPLE_BITS-1:0] r_cur;
    logic [SAMPLE_BITS-1:0] cur;

    assign cur   = i_reading[SAMPLE_BITS-1:0];
    assign n_sum = r_sum + SUM_W'(cur) - SUM_W'(r_win[i_ptr]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctl.accept) begin
            r_win[i_ptr] <= cur;
            r_sum        <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cur <= cur;
        end
    end

    assign o_sum = r_sum;
    assign o_cur = r_cur;

endmodule

### src/msd_decide.sv
// msd_decide: window averages, per-channel stability, done latch and the
// output register. Depends on msd_pkg.
module msd_decide import msd_pkg::*; #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_pipe_ctl              i_ctl,
    input  logic [SUM_W-1:0]       i_sum [NCH],
    input  logic [SAMPLE_BITS-1:0] i_cur [NCH],
    input  logic [DELTA_W-1:0]     i_delta,
    output logic [NCH-1:0]         o_stable,
    output logic                   o_done,
    output logic [IN_W-1:0]        o_base [NCH]
);

    // floor(sum / WINDOW) as (sum * MULT) >> SHIFT, exact over 16-bit sums
    localparam int          LOG_W  = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int          SHIFT  = SUM_W + LOG_W;
    localparam int          PROD_W = 2 * SUM_W + 1;
    localparam longint unsigned MULT_L =
        ((64'd1 << SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [SUM_W:0] MULT = MULT_L[SUM_W:0];

    logic [PROD_W-1:0]      prod   [NCH];
    logic [SAMPLE_BITS-1:0] avg    [NCH];
    logic [SAMPLE_BITS-1:0] diff   [NCH];
    logic [NCH-1:0]         stable;
    logic [NCH-1:0]         r_stable;
    logic                   r_done;
    logic [SAMPLE_BITS-1:0] r_base [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            prod[c]   = PROD_W'(i_sum[c]) * PROD_W'(MULT);
            avg[c]    = prod[c][SHIFT +: SAMPLE_BITS];
            diff[c]   = (avg[c] >= i_cur[c]) ? (avg[c] - i_cur[c]) : (i_cur[c] - avg[c]);
            stable[c] = diff[c] < SAMPLE_BITS'(i_delta);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                r_base[c] <= '0;
            end
        end else if (i_ctl.retire && !r_done && (&stable)) begin
            r_done <= 1'b1;
            for (int c = 0; c < NCH; c++) begin
                r_base[c] <= avg[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.retire) begin
            r_stable <= r_done ? '1 : stable;
        end
    end

    assign o_stable = r_stable;
    assign o_done   = r_done;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            o_base[c] = IN_W'(r_base[c]);
        end
    end

endmodule

### src/moving_average_settle_detector.sv
// moving_average_settle_detector: top level, handshake and window pointer.
// Depends on msd_pkg, msd_cfg, msd_channel, msd_decide.
//
//  channel  | dir | tdata (low bit up)                    | tuser
//  s_axis   | in  | ammonia, reducing, oxidizing reading   | -
//  m_axis   | out | 3 stable flags, 3 base values          | calibration_done
//  apb      | cfg | settle_delta at byte address 0         | -
//
// An accepted word passes stage B, then the output register; one word per cycle
// while m_axis takes words. The window update and running sum land in stage B; the
// divide by WINDOW (a constant multiply) and compare sit in the following stage.
// Reset clears the windows, sums, pointer and done latch at once.
// A stalled m_axis holds its word; s_axis keeps accepting while stage B is
// empty or moves on.
module moving_average_settle_detector import msd_pkg::*; #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [11:0] ammonia, [23:12] reducing,
                                                  // [35:24] oxidizing, [39:36] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [0] ammonia_stable, [1] reducing_stable,
                                                  // [2] oxidizing_stable, [14:3] ammonia_base,
                                                  // [26:15] reducing_base,
                                                  // [38:27] oxidizing_base, [39] zero
    output logic                  m_axis_tuser,   // [0] calibration_done
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_pipe_ctl              ctl;
    logic                   out_ready;
    logic                   r_b_valid;
    logic                   r_o_valid;
    logic [PTR_W-1:0]       r_ptr;
    logic [DELTA_W-1:0]     settle_delta;
    logic [SUM_W-1:0]       sum  [NCH];
    logic [SAMPLE_BITS-1:0] cur  [NCH];
    logic [NCH-1:0]         stable;
    logic                   done;
    logic [IN_W-1:0]        base [NCH];

    assign out_ready     = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_b_valid || out_ready;
    assign ctl.accept    = s_axis_tvalid && s_axis_tready;
    assign ctl.retire    = r_b_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_ptr     <= '0;
        end else begin
            if (ctl.accept) begin
                r_b_valid <= 1'b1;
                r_ptr     <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
            end else if (ctl.retire) begin
                r_b_valid <= 1'b0;
            end
            if (ctl.retire) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    msd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_settle_delta (settle_delta)
    );

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        msd_channel #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS),
            .PTR_W       (PTR_W)
        ) u_channel (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_ptr     (r_ptr),
            .i_reading (s_axis_tdata[c*IN_W +: IN_W]),
            .o_sum     (sum[c]),
            .o_cur     (cur[c])
        );
    end

    msd_decide #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sum    (sum),
        .i_cur    (cur),
        .i_delta  (settle_delta),
        .o_stable (stable),
        .o_done   (done),
        .o_base   (base)
    );

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = done;
    assign m_axis_tdata  = {1'b0, base[2], base[1], base[0], stable};

endmodule

### src/msd_check.sv
// msd_check: port-level assertions for moving_average_settle_detector,
// bound to the top level. Depends on msd_pkg.
module msd_check import msd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    logic                 r_seen_done;
    logic [M_TDATA_W-1:0] r_done_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_done <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser && !r_seen_done) begin
            r_seen_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tuser && !r_seen_done) begin
            r_done_word <= m_axis_tdata;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_done_all_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[NCH-1:0] == '1)
        else $error("done without all channels stable");

    a_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[M_TDATA_W-1:NCH] == '0)
        else $error("base values nonzero before done");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_done |-> m_axis_tuser && m_axis_tdata == r_done_word)
        else $error("result changed after calibration done");

endmodule

bind moving_average_settle_detector msd_check u_check (.*);
